FILE: src/ple_pkg.sv
// Shared types, codes and constants for the positional list engine.
package ple_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int FUNC_W       = 3;
  localparam int KIND_W       = 2;

  localparam logic [FUNC_W-1:0] FN_LENGTH = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd4;

  localparam logic [KIND_W-1:0] RK_LENGTH = 2'd0;
  localparam logic [KIND_W-1:0] RK_READ   = 2'd1;
  localparam logic [KIND_W-1:0] RK_ELEM   = 2'd2;
  localparam logic [KIND_W-1:0] RK_EMPTY  = 2'd3;

  localparam logic signed [DATA_W-1:0] MINUS_ONE = '1;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } ple_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]        result_kind;
    logic signed [DATA_W-1:0] result_value;
    logic                     out_of_range;
    logic                     last;
  } ple_out_t;

endpackage

FILE: src/ple_ram.sv
// Entry store: one write port, one read port with registered read data.
module ple_ram #(
  parameter int DEPTH = ple_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic signed [ple_pkg::DATA_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic signed [ple_pkg::DATA_W-1:0] rdata
);

  logic signed [ple_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/positional_list_engine.sv
// Top level of the positional list engine: request decode, shift sequencer, result register.
//
//   channel | ports                      | transaction
//   --------+----------------------------+----------------------------------------
//   in      | in_valid, in_ready, in_data | one request (func, position, item_value)
//   out     | out_valid, out_ready, out_data | one result (kind, value, range, last)
//
// Length, missed read, empty dump, and insert/remove at the tail are handled in S_IDLE on acceptance.
// A read in range passes through S_RD, as the entry memory has registered read data.
// Insert/remove that moves entries steps through S_SHIFT, S_FLUSH and, for insert, S_FIN:
// one entry per cycle through the one-read, one-write pipeline on the entry memory.
// A dump reads each element through S_DRD and S_DLD; out_ready low stalls it.
// Synchronous reset empties the list; entry contents are not cleared.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ple_pkg::ple_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ple_pkg::ple_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > ple_pkg::POS_W) ? LW : ple_pkg::POS_W) + 1;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_DRD   = 3'd5;
  localparam logic [2:0] S_DLD   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          down_r, down_nxt;
  logic signed [ple_pkg::DATA_W-1:0] val_r, val_nxt;
  ple_pkg::ple_out_t out_r, out_nxt;

  logic          accept;
  logic          out_load;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic signed [ple_pkg::DATA_W-1:0] wdata;
  logic signed [ple_pkg::DATA_W-1:0] rdata;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] len_ext;
  logic [AW-1:0] pos_a;

  ple_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign pos_ext   = CW'(in_data.position);
  assign len_ext   = CW'(len_r);
  assign pos_a     = in_data.position[AW-1:0];
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    pend_nxt      = 1'b0;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    wa_nxt        = wa_r;
    down_nxt      = down_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    out_load      = 1'b0;
    we            = 1'b0;
    waddr         = wa_r;
    wdata         = rdata;
    raddr         = cur_r;

    unique case (state_r)
      S_IDLE: begin
        raddr = pos_a;
        if (accept) begin
          unique case (in_data.func)
            ple_pkg::FN_LENGTH: begin
              out_load = 1'b1;
              out_nxt  = '{ple_pkg::RK_LENGTH, ple_pkg::DATA_W'(len_r), 1'b0, 1'b1};
            end
            ple_pkg::FN_INSERT: begin
              if (len_r == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = in_data.item_value;
                len_nxt = len_r + LW'(1);
              end else if (pos_ext <= len_ext && len_r != CAP_L) begin
                if (pos_ext == len_ext) begin
                  we      = 1'b1;
                  waddr   = pos_a;
                  wdata   = in_data.item_value;
                  len_nxt = len_r + LW'(1);
                end else begin
                  state_nxt = S_SHIFT;
                  cur_nxt   = AW'(len_r - LW'(1));
                  end_nxt   = pos_a;
                  down_nxt  = 1'b1;
                  val_nxt   = in_data.item_value;
                end
              end
            end
            ple_pkg::FN_READ: begin
              if (pos_ext < len_ext) begin
                state_nxt = S_RD;
              end else begin
                out_load = 1'b1;
                out_nxt  = '{ple_pkg::RK_READ, ple_pkg::MINUS_ONE, 1'b1, 1'b1};
              end
            end
            ple_pkg::FN_REMOVE: begin
              if (pos_ext < len_ext) begin
                if (pos_ext == len_ext - CW'(1)) begin
                  len_nxt = len_r - LW'(1);
                end else begin
                  state_nxt = S_SHIFT;
                  cur_nxt   = AW'(pos_a + AW'(1));
                  end_nxt   = AW'(len_r - LW'(1));
                  down_nxt  = 1'b0;
                end
              end
            end
            ple_pkg::FN_DUMP: begin
              if (len_r == '0) begin
                out_load = 1'b1;
                out_nxt  = '{ple_pkg::RK_EMPTY, ple_pkg::MINUS_ONE, 1'b0, 1'b1};
              end else begin
                state_nxt = S_DRD;
                cur_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        pend_nxt = 1'b1;
        wa_nxt   = down_r ? AW'(cur_r + AW'(1)) : AW'(cur_r - AW'(1));
        we       = pend_r;
        if (cur_r == end_r) begin
          state_nxt = S_FLUSH;
        end else begin
          cur_nxt = down_r ? AW'(cur_r - AW'(1)) : AW'(cur_r + AW'(1));
        end
      end
      S_FLUSH: begin
        we = 1'b1;
        if (down_r) begin
          state_nxt = S_FIN;
        end else begin
          len_nxt   = len_r - LW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        we        = 1'b1;
        waddr     = end_r;
        wdata     = val_r;
        len_nxt   = len_r + LW'(1);
        state_nxt = S_IDLE;
      end
      S_RD: begin
        out_load  = 1'b1;
        out_nxt   = '{ple_pkg::RK_READ, rdata, 1'b0, 1'b1};
        state_nxt = S_IDLE;
      end
      S_DRD: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_DLD;
        end
      end
      S_DLD: begin
        out_load = 1'b1;
        out_nxt  = '{ple_pkg::RK_ELEM, rdata, 1'b0,
                     (LW'(cur_r) + LW'(1)) == len_r};
        if ((LW'(cur_r) + LW'(1)) == len_r) begin
          state_nxt = S_IDLE;
        end else begin
          cur_nxt   = AW'(cur_r + AW'(1));
          state_nxt = S_DRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    end_r  <= end_nxt;
    wa_r   <= wa_nxt;
    down_r <= down_nxt;
    val_r  <= val_nxt;
    out_r  <= out_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_L)
    else $error("list length above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && pend_r) |-> (wa_r != cur_r))
    else $error("shift read and write hit the same entry");

  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> pend_r)
    else $error("flush without pending read data");

endmodule

FILE: sim/positional_list_checker.sv
// Scoreboard for the positional list engine: models the list and checks every result.
module positional_list_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  ple_pkg::ple_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  ple_pkg::ple_out_t out_data,
  output int                mismatches,
  output int                answers_awaited,
  output int                answers_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [ple_pkg::DATA_W-1:0] entries_q [CAPACITY];
  int                                list_len;
  ple_pkg::ple_out_t                 answers_q [$];
  int                                error_total;
  int                                checked_total;

  function automatic ple_pkg::ple_out_t make_answer(logic [ple_pkg::KIND_W-1:0] kind,
                                                    logic signed [ple_pkg::DATA_W-1:0] value,
                                                    logic oor, logic fin);
    ple_pkg::ple_out_t a;
    a.result_kind  = kind;
    a.result_value = value;
    a.out_of_range = oor;
    a.last         = fin;
    return a;
  endfunction

  function automatic void apply_list_request(ple_pkg::ple_in_t req);
    int p;
    int j;
    p = int'(req.position);
    case (req.func)
      ple_pkg::FN_LENGTH: begin
        answers_q.push_back(make_answer(ple_pkg::RK_LENGTH, ple_pkg::DATA_W'(list_len),
                                        1'b0, 1'b1));
      end
      ple_pkg::FN_INSERT: begin
        if (list_len == 0) begin
          entries_q[0] = req.item_value;
          list_len = 1;
        end else if (p <= list_len && list_len < CAPACITY) begin
          for (j = list_len; j > p; j--) entries_q[j] = entries_q[j-1];
          entries_q[p] = req.item_value;
          list_len++;
        end
      end
      ple_pkg::FN_READ: begin
        if (p < list_len) begin
          answers_q.push_back(make_answer(ple_pkg::RK_READ, entries_q[p], 1'b0, 1'b1));
        end else begin
          answers_q.push_back(make_answer(ple_pkg::RK_READ, ple_pkg::MINUS_ONE, 1'b1, 1'b1));
        end
      end
      ple_pkg::FN_REMOVE: begin
        if (p < list_len) begin
          for (j = p; j + 1 < list_len; j++) entries_q[j] = entries_q[j+1];
          list_len--;
        end
      end
      ple_pkg::FN_DUMP: begin
        if (list_len == 0) begin
          answers_q.push_back(make_answer(ple_pkg::RK_EMPTY, ple_pkg::MINUS_ONE, 1'b0, 1'b1));
        end else begin
          for (j = 0; j < list_len; j++)
            answers_q.push_back(make_answer(ple_pkg::RK_ELEM, entries_q[j], 1'b0,
                                            j == list_len - 1));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int field_differs(string name, logic [ple_pkg::DATA_W-1:0] want,
                                       logic [ple_pkg::DATA_W-1:0] got);
    if (got === want) return 0;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    ple_pkg::ple_out_t want;
    int                bad;
    if (!rst_n) begin
      answers_q.delete();
      list_len      = 0;
      error_total   = 0;
      checked_total = 0;
    end else begin
      // results leave before any request accepted on the same edge can cause one
      if (out_valid && out_ready) begin
        checked_total++;
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d value %0h oor %0b last %0b",
                   $time, out_data.result_kind, out_data.result_value,
                   out_data.out_of_range, out_data.last);
          error_total++;
        end else begin
          want = answers_q.pop_front();
          bad  = field_differs("result_kind", want.result_kind, out_data.result_kind)
               + field_differs("result_value", want.result_value, out_data.result_value)
               + field_differs("out_of_range", want.out_of_range, out_data.out_of_range)
               + field_differs("last", want.last, out_data.last);
          if (bad != 0) error_total++;
        end
      end
      if (in_valid && in_ready) apply_list_request(in_data);
    end
    mismatches      <= error_total;
    answers_awaited <= answers_q.size();
    answers_checked <= checked_total;
  end

endmodule

FILE: sim/positional_list_engine_tb.sv
// Testbench top for the positional list engine: clock, reset, request stimulus and verdict.
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = ple_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 430;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  ple_pkg::ple_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  ple_pkg::ple_out_t out_data;

  int send_idle_pct;
  int recv_idle_pct;
  int shadow_len;
  int peak_len;
  int requests_sent;
  int dumps_sent;
  int cycles;
  int mismatches;
  int answers_awaited;
  int answers_checked;

  positional_list_engine #(.CAPACITY(CAPACITY)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  positional_list_checker #(.CAPACITY(CAPACITY)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .answers_awaited(answers_awaited),
    .answers_checked(answers_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic ple_pkg::ple_in_t build_request(logic [ple_pkg::FUNC_W-1:0] f,
                                                     logic [ple_pkg::POS_W-1:0] p,
                                                     logic signed [ple_pkg::DATA_W-1:0] v);
    ple_pkg::ple_in_t r;
    r.func       = f;
    r.position   = p;
    r.item_value = v;
    return r;
  endfunction

  task automatic send_request(ple_pkg::ple_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    case (req.func)
      ple_pkg::FN_INSERT: begin
        if (shadow_len == 0) shadow_len = 1;
        else if (req.position <= shadow_len && shadow_len < CAPACITY) shadow_len++;
      end
      ple_pkg::FN_REMOVE: if (req.position < shadow_len) shadow_len--;
      ple_pkg::FN_DUMP: dumps_sent++;
      default: ;
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
  endtask

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycles, answers_awaited);
    $display("positional_list_engine_tb: errors");
    $finish;
  end

  initial begin : stimulus
    ple_pkg::ple_in_t                  req;
    logic signed [ple_pkg::DATA_W-1:0] val;
    logic [ple_pkg::POS_W-1:0]         pos;
    bit                                growing;
    int                                r;
    int                                ins_cut;
    int                                rem_cut;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    out_ready     <= 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 62;
    shadow_len    = 0;
    peak_len      = 0;
    requests_sent = 0;
    dumps_sent    = 0;
    growing       = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    send_request(build_request(ple_pkg::FN_LENGTH, 8'd0, 32'sd0));
    send_request(build_request(ple_pkg::FN_DUMP, 8'd0, 32'sd0));
    send_request(build_request(ple_pkg::FN_READ, 8'd0, 32'sd0));
    send_request(build_request(ple_pkg::FN_REMOVE, 8'd0, 32'sd0));
    // insert on empty list lands at the front
    send_request(build_request(ple_pkg::FN_INSERT, 8'd255, 32'sh8000_0000));
    // past the end: dropped
    send_request(build_request(ple_pkg::FN_INSERT, 8'd5, 32'sd1));
    send_request(build_request(ple_pkg::FN_INSERT, 8'd0, 32'sh7fff_ffff));
    send_request(build_request(ple_pkg::FN_INSERT, 8'd2, ple_pkg::MINUS_ONE));
    send_request(build_request(ple_pkg::FN_INSERT, 8'd1, 32'sh5555_5555));
    send_request(build_request(ple_pkg::FN_READ, 8'd0, 32'sd0));
    send_request(build_request(ple_pkg::FN_READ, 8'd3, 32'sd0));
    send_request(build_request(ple_pkg::FN_READ, 8'd4, 32'sd0));
    send_request(build_request(ple_pkg::FN_READ, 8'd255, ple_pkg::MINUS_ONE));
    // unused codes
    send_request(build_request(3'd5, 8'd255, ple_pkg::MINUS_ONE));
    send_request(build_request(3'd6, 8'd0, 32'sh2aaa_aaaa));
    send_request(build_request(3'd7, 8'd1, ple_pkg::MINUS_ONE));
    send_request(build_request(ple_pkg::FN_REMOVE, 8'd255, 32'sd0));
    send_request(build_request(ple_pkg::FN_REMOVE, 8'd1, 32'sd0));
    send_request(build_request(ple_pkg::FN_REMOVE, 8'd2, 32'sd0));
    send_request(build_request(ple_pkg::FN_DUMP, 8'd0, 32'sd0));
    send_request(build_request(ple_pkg::FN_LENGTH, 8'd0, 32'sd0));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 14;
      end else if (k == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // fill the list to capacity, linger there, then drain it
      if (growing && shadow_len == CAPACITY && $urandom_range(7) == 0) growing = 1'b0;
      else if (!growing && shadow_len <= 1) growing = 1'b1;
      ins_cut = growing ? 60 : 20;
      rem_cut = ins_cut + (growing ? 8 : 55);
      r   = $urandom_range(99);
      val = $urandom;
      pos = ple_pkg::POS_W'($urandom_range(shadow_len));
      if (r < ins_cut) req = build_request(ple_pkg::FN_INSERT, pos, val);
      else if (r < rem_cut) req = build_request(ple_pkg::FN_REMOVE, pos, val);
      else if (r < 82) req = build_request(ple_pkg::FN_READ, pos, val);
      else if (r < 87) req = build_request(ple_pkg::FN_LENGTH, pos, val);
      else if (r < 91) req = build_request(ple_pkg::FN_DUMP, pos, val);
      else req = build_request(ple_pkg::FUNC_W'($urandom_range(7)),
                               ple_pkg::POS_W'($urandom), val);
      send_request(req);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (answers_awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests including %0d dumps; %0d results checked.",
             requests_sent, dumps_sent, answers_checked);
    $display("List reached %0d of %0d entries; %0d mismatching results.",
             peak_len, CAPACITY, mismatches);
    if (mismatches == 0) begin
      $display("positional_list_engine_tb: clean");
    end else begin
      $display("positional_list_engine_tb: errors");
    end
    $finish;
  end

endmodule
